// ----- rtl/skf_pkg.sv -----
// -----------------------------------------------------------------------------
// skf_pkg: shared constants and types for the scalar Kalman filter core
// Gain format, register indexes, defaults and the divider status bundle.
// -----------------------------------------------------------------------------
package skf_pkg;

	// default data format, Q16.16
	localparam int DATA_WIDTH_DEFAULT = 32;
	localparam int FRAC_BITS_DEFAULT  = 16;

	// gain is unsigned Q0.16, one extra bit so that exactly one fits
	localparam int GAIN_BITS  = 16;
	localparam int GAIN_WIDTH = GAIN_BITS + 1;
	localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_BITS;

	// divider iteration counter, one quotient bit per cycle
	localparam int CNT_WIDTH = $clog2(GAIN_BITS);

	// configuration register indexes
	localparam int CFG_INDEX_WIDTH = 4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASURE_NOISE = CFG_INDEX_WIDTH'(1);

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} skf_div_stat_t;

endpackage

// ----- rtl/skf_meas_if.sv -----
// -----------------------------------------------------------------------------
// skf_meas_if: measurement channel
// valid/ready handshake carrying one signed fixed-point sample.
// -----------------------------------------------------------------------------
interface skf_meas_if #(
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink   (input valid, input measurement, output ready);
endinterface

// ----- rtl/skf_result_if.sv -----
// -----------------------------------------------------------------------------
// skf_result_if: result channel
// valid/ready handshake carrying the filtered estimate and the gain used.
// -----------------------------------------------------------------------------
interface skf_result_if #(
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
	import skf_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] estimate;
	logic [GAIN_WIDTH-1:0]        gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink   (input valid, input estimate, input gain, output ready);
endinterface

// ----- rtl/skf_div.sv -----
// -----------------------------------------------------------------------------
// skf_div: iterative gain divider
// Computes floor(pred * 2^16 / (pred + noise)) one quotient bit per cycle
// by restoring division. Zero denominator gives zero, zero noise gives one.
// -----------------------------------------------------------------------------
module skf_div #(
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [DATA_WIDTH-1:0]           pred,
	input  logic [DATA_WIDTH-1:0]           noise,
	output skf_pkg::skf_div_stat_t          stat,
	output logic [skf_pkg::GAIN_WIDTH-1:0]  gain
);
	import skf_pkg::*;

	logic [DATA_WIDTH:0]   denom_q;
	logic [DATA_WIDTH:0]   rem_q;
	logic [GAIN_BITS-1:0]  quo_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  zero_q;
	logic                  full_q;

	logic [DATA_WIDTH+1:0] rem2;
	logic [DATA_WIDTH+1:0] diff;
	logic                  ge;

	// one shift, compare and subtract step
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, denom_q};
	assign ge   = (rem2 >= {1'b0, denom_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(GAIN_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			denom_q <= {1'b0, pred} + {1'b0, noise};
			rem_q   <= {1'b0, pred};
			quo_q   <= '0;
			zero_q  <= (pred == '0) && (noise == '0);
			full_q  <= (noise == '0) && (pred != '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_WIDTH:0] : rem2[DATA_WIDTH:0];
			quo_q <= {quo_q[GAIN_BITS-2:0], ge};
		end
	end

	// special cases override the iterated quotient
	always_comb begin
		priority if (zero_q)
			gain = '0;
		else if (full_q)
			gain = GAIN_ONE;
		else
			gain = {1'b0, quo_q};
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/scalar_kalman_filter_core.sv -----
// -----------------------------------------------------------------------------
// scalar_kalman_filter_core: one-dimensional Kalman filter
// Smooths a stream of signed fixed-point samples with a scalar Kalman update
// on an iterative divider and one shared multiplier.
// -----------------------------------------------------------------------------
//
//  channel   kind         fields                         handshake
//  --------  -----------  -----------------------------  -----------------
//  sample    sink         measurement                    valid / ready
//  result    source       estimate, gain                 valid / ready
//  cfg       write only   cfg_index, cfg_wdata           cfg_wr_en
//
//  Between one sample's transfer and the next possible transfer the
//  sequencer runs the predict step, the one-bit-per-cycle gain divider,
//  two passes through the shared multiplier and the covariance and
//  output updates.
//  A finished result sits in the output register; the next sample is
//  taken while it waits. The sequencer only stalls on a full output.
//  Reset sets covariance to 1.03, estimate to 0, Q to 0 and R to 1.0.
//
// -----------------------------------------------------------------------------
module scalar_kalman_filter_core #(
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT,
	parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	skf_meas_if.sink                            sample,
	skf_result_if.source                        result,
	input  logic                                cfg_wr_en,
	input  logic [skf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]               cfg_wdata
);
	import skf_pkg::*;

	localparam int MUL_A_WIDTH = GAIN_WIDTH + 1;
	localparam int MUL_B_WIDTH = DATA_WIDTH + 1;
	localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

	localparam logic [DATA_WIDTH-1:0] COV_RESET =
		DATA_WIDTH'((longint'(103) << FRAC_BITS) / 100);
	localparam logic [DATA_WIDTH-1:0] R_RESET = DATA_WIDTH'(longint'(65536));
	localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PRED = 8'b0000_0010,
		ST_DIVS = 8'b0000_0100,
		ST_DIVW = 8'b0000_1000,
		ST_MULE = 8'b0001_0000,
		ST_EST  = 8'b0010_0000,
		ST_COV  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;

	// configuration and filter state
	logic [DATA_WIDTH-1:0]          q_noise_q;
	logic [DATA_WIDTH-1:0]          r_noise_q;
	logic [DATA_WIDTH-1:0]          cov_q;
	logic signed [DATA_WIDTH-1:0]   est_q;

	// per-sample working registers
	logic signed [DATA_WIDTH-1:0]   meas_q;
	logic [DATA_WIDTH-1:0]          pred_q;
	logic signed [DATA_WIDTH:0]     err_q;
	logic [GAIN_WIDTH-1:0]          gain_q;
	logic signed [PROD_WIDTH-1:0]   prod_q;

	// output register
	logic                           out_valid_q;
	logic signed [DATA_WIDTH-1:0]   out_est_q;
	logic [GAIN_WIDTH-1:0]          out_gain_q;

	logic                           in_xfer;
	logic                           out_free;
	logic [DATA_WIDTH:0]            pred_sum;
	logic [DATA_WIDTH-1:0]          pred_sat;
	logic signed [DATA_WIDTH:0]     err_d;
	logic signed [MUL_A_WIDTH-1:0]  mul_a;
	logic signed [MUL_B_WIDTH-1:0]  mul_b;
	logic signed [PROD_WIDTH-1:0]   mul_p;
	logic signed [DATA_WIDTH:0]     delta;
	logic signed [DATA_WIDTH+1:0]   est_sum;
	logic signed [DATA_WIDTH-1:0]   est_sat;
	logic [DATA_WIDTH-1:0]          cov_new;

	skf_div_stat_t                  div_stat;
	logic [GAIN_WIDTH-1:0]          div_gain;

	assign in_xfer  = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	// predicted covariance, saturating, and the innovation
	assign pred_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
	assign pred_sat = pred_sum[DATA_WIDTH] ? '1 : pred_sum[DATA_WIDTH-1:0];
	assign err_d    = {meas_q[DATA_WIDTH-1], meas_q} - {est_q[DATA_WIDTH-1], est_q};

	// gain divider
	skf_div #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIVS),
		.pred   (pred_q),
		.noise  (r_noise_q),
		.stat   (div_stat),
		.gain   (div_gain)
	);

	// shared multiplier: gain * error, then (1 - gain) * prediction
	always_comb begin
		if (state_q == ST_MULE) begin
			mul_a = {1'b0, gain_q};
			mul_b = err_q;
		end else begin
			mul_a = {1'b0, GAIN_ONE - gain_q};
			mul_b = {1'b0, pred_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	// estimate step, floor of the scaled product, then saturation
	assign delta   = prod_q[GAIN_BITS +: DATA_WIDTH+1];
	assign est_sum = {{2{est_q[DATA_WIDTH-1]}}, est_q} + {delta[DATA_WIDTH], delta};
	always_comb begin
		priority if ((est_sum[DATA_WIDTH+1:DATA_WIDTH-1] != '0) &&
				(est_sum[DATA_WIDTH+1:DATA_WIDTH-1] != '1))
			est_sat = est_sum[DATA_WIDTH+1] ? SMIN : SMAX;
		else
			est_sat = est_sum[DATA_WIDTH-1:0];
	end
	assign cov_new = prod_q[GAIN_BITS +: DATA_WIDTH];

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_PRED;
			ST_PRED: state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIVW;
			ST_DIVW: if (div_stat.done) state_d = ST_MULE;
			ST_MULE: state_d = ST_EST;
			ST_EST:  state_d = ST_COV;
			ST_COV:  state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= '0;
			r_noise_q <= R_RESET;
			cov_q     <= COV_RESET;
			est_q     <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == REG_PROCESS_NOISE))
				q_noise_q <= cfg_wdata;
			if (cfg_wr_en && (cfg_index == REG_MEASURE_NOISE))
				r_noise_q <= cfg_wdata;
			if (state_q == ST_EST)
				est_q <= est_sat;
			if (state_q == ST_COV)
				cov_q <= cov_new;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			meas_q <= sample.measurement;
		if (state_q == ST_PRED) begin
			pred_q <= pred_sat;
			err_q  <= err_d;
		end
		if ((state_q == ST_DIVW) && div_stat.done)
			gain_q <= div_gain;
		if ((state_q == ST_MULE) || (state_q == ST_EST))
			prod_q <= mul_p;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_est_q  <= est_q;
			out_gain_q <= gain_q;
		end
	end

	assign sample.ready    = (state_q == ST_IDLE);
	assign result.valid    = out_valid_q;
	assign result.estimate = out_est_q;
	assign result.gain     = out_gain_q;

`ifndef SYNTH
	// one sample at a time: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !sample.ready)
		else $error("sample taken while another is in work");

	// the gain never exceeds one
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.gain <= GAIN_ONE))
		else $error("gain above one");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIVW))
		else $error("divider done outside its wait state");

	// the updated covariance never exceeds the prediction
	a_cov_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COV) |-> (cov_new <= pred_q))
		else $error("covariance grew past prediction");

	// a result appears only out of the final state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the output state");
`endif

endmodule
